[design/bbp_pkg.sv]
// Shared constants and types for the bicubic Bezier patch evaluator.
// No dependencies; imported by the top level.
package bbp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int IN_COORD_W      = 32;
    localparam int PARAM_W         = 17;
    localparam int INDEX_W         = 4;
    localparam int NORMAL_W        = 16;
    localparam int NUM_SLOTS       = 16;
    localparam int NUM_AXES        = 3;
    localparam int S_DATA_W        = 136;
    localparam int M_DATA_W        = 144;

    localparam logic [PARAM_W-1:0] PARAM_ONE = 17'd65536;

    // Input item kinds carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Job numbers within one axis pass
    localparam logic [3:0] JOB_SURF = 4'd8;
    localparam logic [3:0] JOB_VTAN = 4'd9;

    typedef logic [63:0] mag_t;

endpackage

[design/bicubic_bezier_patch_eval.sv]
// Bicubic Bezier patch evaluator: control point store, de Casteljau sequencer,
// shared multiplier, normal reduction, square root and divide steps.
// Depends on bbp_pkg and bbp_ram.
//
// A load beat (tuser = 0) writes one control point in the cycle it is taken
// and the block stays ready. An evaluate beat (tuser = 1) runs 30 cubic
// evaluations (3 axes, 10 per axis) of 6 lerps each, every lerp being a
// multiply step and an add step on the one shared multiplier, plus point
// fetches from the control point RAM, the tangent and cross product
// reductions (one halving per step), and the cross product, sum of squares,
// square root and divide steps per normal component; a degenerate normal
// skips the steps after the cross product.
// s_tready stays low while an evaluation runs. The result waits in an output
// register, so a new load or evaluate beat is taken while it is still pending.
module bicubic_bezier_patch_eval
    import bbp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // point_index[3:0], coord_x, coord_y, coord_z, param_u, param_v, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // cmd
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // surf_x, surf_y, surf_z, normal_x, normal_y, normal_z
    output logic [M_DATA_W-1:0] m_tdata,
    // normal_degenerate
    output logic                m_tuser
);

    localparam int CW   = COORD_WIDTH;
    localparam int MA   = (CW + 1 > 32) ? CW + 1 : 32;
    localparam int PW   = MA + 32;
    localparam int RAMW = CW * NUM_AXES;
    localparam int AW   = $clog2(NUM_SLOTS);

    typedef enum logic [3:0] {
        IDLE, FETCH, LMUL, LADD, JOBEND, RED_T, XMUL, XACC,
        CHK, RED_C, SQMUL, SQACC, SQRT, DIVINIT, DIV, DONE
    } state_t;

    typedef logic signed [CW-1:0] coord_t;

    function automatic coord_t sat_in(input logic signed [IN_COORD_W-1:0] x);
        logic signed [63:0] w;
        logic signed [63:0] hi;
        w  = 64'(x);
        hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
        if (w > hi)
        begin
            w = hi;
        end
        else if (w < -hi - 64'sd1)
        begin
            w = -hi - 64'sd1;
        end
        return w[CW-1:0];
    endfunction

    function automatic logic [31:0] sat_out(input coord_t x);
        logic signed [63:0] w;
        w = 64'(x);
        if (w > 64'sd2147483647)
        begin
            w = 64'sd2147483647;
        end
        else if (w < -64'sd2147483648)
        begin
            w = -64'sd2147483648;
        end
        return w[31:0];
    endfunction

    function automatic logic signed [31:0] smag(input logic s, input mag_t m);
        logic signed [31:0] t;
        t = signed'({2'b00, m[29:0]});
        return s ? -t : t;
    endfunction

    function automatic logic [1:0] mod3_p1(input logic [1:0] c);
        logic [1:0] r;
        case (c)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // control state
    state_t      state_reg, state_next;
    logic        mv_reg, mv_next;
    logic [3:0]  step_reg, step_next;
    logic [3:0]  job_reg, job_next;
    logic [1:0]  axis_reg, axis_next;
    logic [1:0]  comp_reg, comp_next;

    // payload
    logic [PARAM_W-1:0] u_reg, u_next, v_reg, v_next;
    coord_t      p_reg [4], p_next [4];
    coord_t      rc_reg [4], rc_next [4];
    coord_t      cl_reg [4], cl_next [4];
    coord_t      pnt_reg [3], pnt_next [3];
    mag_t        tu_mag_reg [3], tu_mag_next [3];
    mag_t        tv_mag_reg [3], tv_mag_next [3];
    mag_t        cr_mag_reg [3], cr_mag_next [3];
    logic [2:0]  tu_sgn_reg, tu_sgn_next, tv_sgn_reg, tv_sgn_next;
    logic [2:0]  cr_sgn_reg, cr_sgn_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [63:0]   acc_reg, acc_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] rt_reg, rt_next;
    logic [63:0] bit_reg, bit_next;
    logic [31:0] len_reg, len_next;
    logic [45:0] rem_reg, rem_next, dv_reg, dv_next;
    logic [14:0] q_reg, q_next;
    logic signed [NORMAL_W-1:0] nrm_reg [3], nrm_next [3];
    logic        deg_reg, deg_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic        out_deg_reg, out_deg_next;

    // RAM
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic [RAMW-1:0] ram_rdata;
    logic [RAMW-1:0] ram_wdata;

    logic in_fire;
    assign in_fire = s_tvalid && s_tready;
    assign ram_we  = in_fire && (s_tuser == CMD_LOAD);
    assign ram_wdata = {sat_in(s_tdata[99:68]), sat_in(s_tdata[67:36]),
                        sat_in(s_tdata[35:4])};

    bbp_ram #(
        .WIDTH(RAMW),
        .DEPTH(NUM_SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(s_tdata[INDEX_W-1:0]),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_deg_reg;

    // lerp operand selection: reads p[sel], p[sel+1]; writes p[dst]
    logic [1:0] lsel, ldst;
    always_comb
    begin
        case (step_reg[2:0])
            3'd0:    begin lsel = 2'd0; ldst = 2'd0; end
            3'd1:    begin lsel = 2'd1; ldst = 2'd1; end
            3'd2:    begin lsel = 2'd2; ldst = 2'd2; end
            3'd3:    begin lsel = 2'd0; ldst = 2'd0; end
            3'd4:    begin lsel = 2'd1; ldst = 2'd1; end
            default: begin lsel = 2'd0; ldst = 2'd2; end
        endcase
    end

    logic [1:0]  xc, xn1, xn2, xia, xib;
    logic        xsecond;
    assign xc      = step_reg[2:1];
    assign xsecond = step_reg[0];
    assign xn1     = mod3_p1(xc);
    assign xn2     = mod3_p1(xn1);
    assign xia     = xsecond ? xn2 : xn1;
    assign xib     = xsecond ? xn1 : xn2;

    logic [PARAM_W-1:0] t_cur;
    assign t_cur = (job_reg < 4'd4 || job_reg == JOB_VTAN) ? v_reg : u_reg;

    assign ram_raddr = job_reg[2] ? {step_reg[1:0], job_reg[1:0]}
                                  : {job_reg[1:0], step_reg[1:0]};

    logic signed [CW:0]    ldiff;
    logic signed [MA-1:0]  mul_a;
    logic signed [31:0]    mul_b;
    logic signed [PW-1:0]  lerp_sum;
    logic signed [PW-1:0]  lerp_q;
    logic signed [63:0]    tdiff, tan64, crv, prod64;
    logic                  tu_big, tv_big, cr_big, ge;
    logic [63:0]           sq_try;
    logic [14:0]           q_new;
    logic [15:0]           qn_ext;

    always_comb
    begin
        state_next    = state_reg;
        mv_next       = mv_reg;
        step_next     = step_reg;
        job_next      = job_reg;
        axis_next     = axis_reg;
        comp_next     = comp_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        p_next        = p_reg;
        rc_next       = rc_reg;
        cl_next       = cl_reg;
        pnt_next      = pnt_reg;
        tu_mag_next   = tu_mag_reg;
        tv_mag_next   = tv_mag_reg;
        cr_mag_next   = cr_mag_reg;
        tu_sgn_next   = tu_sgn_reg;
        tv_sgn_next   = tv_sgn_reg;
        cr_sgn_next   = cr_sgn_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        sum_next      = sum_reg;
        rt_next       = rt_reg;
        bit_next      = bit_reg;
        len_next      = len_reg;
        rem_next      = rem_reg;
        dv_next       = dv_reg;
        q_next        = q_reg;
        nrm_next      = nrm_reg;
        deg_next      = deg_reg;
        out_data_next = out_data_reg;
        out_deg_next  = out_deg_reg;

        // shared multiplier operands
        ldiff = {p_reg[lsel + 2'd1][CW-1], p_reg[lsel + 2'd1]}
              - {p_reg[lsel][CW-1], p_reg[lsel]};
        mul_a = MA'(ldiff);
        mul_b = signed'({15'd0, t_cur});
        if (state_reg == XMUL)
        begin
            mul_a = MA'(smag(tu_sgn_reg[xia], tu_mag_reg[xia]));
            mul_b = smag(tv_sgn_reg[xib], tv_mag_reg[xib]);
        end
        else if (state_reg == SQMUL)
        begin
            mul_a = MA'(smag(1'b0, cr_mag_reg[comp_reg]));
            mul_b = smag(1'b0, cr_mag_reg[comp_reg]);
        end

        lerp_sum = prod_reg + PW'(32768);
        lerp_q   = lerp_sum >>> 16;
        tdiff    = 64'(signed'({p_reg[1][CW-1], p_reg[1]} - {p_reg[0][CW-1], p_reg[0]}));
        tan64    = tdiff + (tdiff <<< 1);
        prod64   = prod_reg[63:0];
        crv      = acc_reg - prod64;
        tu_big   = (tu_mag_reg[0][63:30] != '0) || (tu_mag_reg[1][63:30] != '0)
                || (tu_mag_reg[2][63:30] != '0);
        tv_big   = (tv_mag_reg[0][63:30] != '0) || (tv_mag_reg[1][63:30] != '0)
                || (tv_mag_reg[2][63:30] != '0);
        cr_big   = (cr_mag_reg[0][63:30] != '0) || (cr_mag_reg[1][63:30] != '0)
                || (cr_mag_reg[2][63:30] != '0);
        sq_try   = rt_reg + bit_reg;
        ge       = (rem_reg >= dv_reg);
        q_new    = {q_reg[13:0], ge};
        qn_ext   = {1'b0, q_new};

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (in_fire && s_tuser == CMD_EVAL)
                begin
                    u_next     = (s_tdata[116:100] > PARAM_ONE) ? PARAM_ONE
                                                                : s_tdata[116:100];
                    v_next     = (s_tdata[133:117] > PARAM_ONE) ? PARAM_ONE
                                                                : s_tdata[133:117];
                    axis_next  = 2'd0;
                    job_next   = 4'd0;
                    step_next  = 4'd0;
                    state_next = FETCH;
                end
            end
            FETCH:
            begin
                if (job_reg >= JOB_SURF)
                begin
                    if (job_reg == JOB_SURF)
                    begin
                        p_next = rc_reg;
                    end
                    else
                    begin
                        p_next = cl_reg;
                    end
                    step_next  = 4'd0;
                    state_next = LMUL;
                end
                else
                begin
                    if (step_reg != 4'd0)
                    begin
                        p_next[step_reg[1:0] - 2'd1] = ram_rdata[axis_reg * CW +: CW];
                    end
                    if (step_reg == 4'd4)
                    begin
                        step_next  = 4'd0;
                        state_next = LMUL;
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            LMUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = LADD;
            end
            LADD:
            begin
                p_next[ldst] = p_reg[lsel] + lerp_q[CW-1:0];
                if (step_reg == 4'd5)
                begin
                    state_next = JOBEND;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = LMUL;
                end
            end
            JOBEND:
            begin
                step_next = 4'd0;
                if (job_reg < 4'd4)
                begin
                    rc_next[job_reg[1:0]] = p_reg[2];
                end
                else if (job_reg < JOB_SURF)
                begin
                    cl_next[job_reg[1:0]] = p_reg[2];
                end
                else if (job_reg == JOB_SURF)
                begin
                    pnt_next[axis_reg]    = p_reg[2];
                    tu_sgn_next[axis_reg] = tan64[63];
                    tu_mag_next[axis_reg] = tan64[63] ? mag_t'(-tan64) : mag_t'(tan64);
                end
                else
                begin
                    tv_sgn_next[axis_reg] = tan64[63];
                    tv_mag_next[axis_reg] = tan64[63] ? mag_t'(-tan64) : mag_t'(tan64);
                end
                if (job_reg == JOB_VTAN)
                begin
                    job_next = 4'd0;
                    if (axis_reg == 2'd2)
                    begin
                        state_next = RED_T;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = FETCH;
                    end
                end
                else
                begin
                    job_next   = job_reg + 4'd1;
                    state_next = FETCH;
                end
            end
            RED_T:
            begin
                // shift magnitudes together until each is below 2^30
                for (int k = 0; k < 3; k++)
                begin
                    if (tu_big)
                    begin
                        tu_mag_next[k] = tu_mag_reg[k] >> 1;
                    end
                    if (tv_big)
                    begin
                        tv_mag_next[k] = tv_mag_reg[k] >> 1;
                    end
                end
                if (!tu_big && !tv_big)
                begin
                    step_next  = 4'd0;
                    state_next = XMUL;
                end
            end
            XMUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = XACC;
            end
            XACC:
            begin
                if (!xsecond)
                begin
                    acc_next = prod64;
                end
                else
                begin
                    cr_sgn_next[xc] = crv[63];
                    cr_mag_next[xc] = crv[63] ? mag_t'(-crv) : mag_t'(crv);
                end
                if (step_reg == 4'd5)
                begin
                    state_next = CHK;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = XMUL;
                end
            end
            CHK:
            begin
                if (cr_mag_reg[0] == '0 && cr_mag_reg[1] == '0 && cr_mag_reg[2] == '0)
                begin
                    deg_next   = 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        nrm_next[k] = '0;
                    end
                    state_next = DONE;
                end
                else
                begin
                    deg_next   = 1'b0;
                    state_next = RED_C;
                end
            end
            RED_C:
            begin
                if (cr_big)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        cr_mag_next[k] = cr_mag_reg[k] >> 1;
                    end
                end
                else
                begin
                    comp_next  = 2'd0;
                    sum_next   = '0;
                    state_next = SQMUL;
                end
            end
            SQMUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = SQACC;
            end
            SQACC:
            begin
                sum_next = sum_reg + prod_reg[63:0];
                if (comp_reg == 2'd2)
                begin
                    rt_next    = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = SQRT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = SQMUL;
                end
            end
            SQRT:
            begin
                if (bit_reg == '0)
                begin
                    len_next   = (rt_reg == '0) ? 32'd1 : rt_reg[31:0];
                    comp_next  = 2'd0;
                    state_next = DIVINIT;
                end
                else
                begin
                    if (sum_reg >= sq_try)
                    begin
                        sum_next = sum_reg - sq_try;
                        rt_next  = (rt_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        rt_next = rt_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            DIVINIT:
            begin
                rem_next   = {2'b00, cr_mag_reg[comp_reg][29:0], 14'd0}
                           + 46'(len_reg >> 1);
                dv_next    = {len_reg, 14'd0};
                q_next     = '0;
                step_next  = 4'd0;
                state_next = DIV;
            end
            DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dv_reg;
                end
                q_next    = q_new;
                dv_next   = dv_reg >> 1;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd14)
                begin
                    nrm_next[comp_reg] = cr_sgn_reg[comp_reg] ? -signed'(qn_ext)
                                                              : signed'(qn_ext);
                    if (comp_reg == 2'd2)
                    begin
                        state_next = DONE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = DIVINIT;
                    end
                end
            end
            DONE:
            begin
                // hold until the output register is free
                if (!mv_reg || m_tready)
                begin
                    out_data_next = {nrm_reg[2], nrm_reg[1], nrm_reg[0],
                                     sat_out(pnt_reg[2]), sat_out(pnt_reg[1]),
                                     sat_out(pnt_reg[0])};
                    out_deg_next  = deg_reg;
                    mv_next       = 1'b1;
                    state_next    = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            mv_reg    <= 1'b0;
            step_reg  <= '0;
            job_reg   <= '0;
            axis_reg  <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            step_reg  <= step_next;
            job_reg   <= job_next;
            axis_reg  <= axis_next;
            comp_reg  <= comp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        p_reg        <= p_next;
        rc_reg       <= rc_next;
        cl_reg       <= cl_next;
        pnt_reg      <= pnt_next;
        tu_mag_reg   <= tu_mag_next;
        tv_mag_reg   <= tv_mag_next;
        cr_mag_reg   <= cr_mag_next;
        tu_sgn_reg   <= tu_sgn_next;
        tv_sgn_reg   <= tv_sgn_next;
        cr_sgn_reg   <= cr_sgn_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        sum_reg      <= sum_next;
        rt_reg       <= rt_next;
        bit_reg      <= bit_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        dv_reg       <= dv_next;
        q_reg        <= q_next;
        nrm_reg      <= nrm_next;
        deg_reg      <= deg_next;
        out_data_reg <= out_data_next;
        out_deg_reg  <= out_deg_next;
    end

endmodule

[design/bbp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bbp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sim/tb_bicubic_bezier_patch_eval.sv]
// Self-checking testbench for bicubic_bezier_patch_eval: loads control points,
// evaluates the patch and checks surface point and unit normal per beat.
// Depends on bbp_pkg and the RTL of the block.
module tb_bicubic_bezier_patch_eval
    import bbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 800;
    localparam int RANDOM_ITEMS   = 1125;

    typedef struct {
        logic                cmd;
        logic [INDEX_W-1:0]  slot;
        logic [31:0]         cx, cy, cz;
        logic [PARAM_W-1:0]  pu, pv;
    } patch_cmd_t;

    typedef struct {
        logic [31:0]         sx, sy, sz;
        logic [NORMAL_W-1:0] nx, ny, nz;
        logic                degen;
    } surface_t;

    typedef struct {
        patch_cmd_t cmd;
        bit         typed;
        surface_t   res;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    bicubic_bezier_patch_eval dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    longint   ctrl_pts [48];
    surface_t surface_expect_q[$];
    int       mismatches;
    int       send_idle;
    int       recv_idle;
    int       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint lerp_fx(longint a, longint b, longint t);
        longint d;
        longint lo;
        longint hi;
        longint fr;
        d  = b - a;
        lo = d & 64'hFFFF;
        hi = (d - lo) >>> 16;
        fr = (lo * t + 32768) >>> 16;
        return a + hi * t + fr;
    endfunction

    task automatic cubic_at(input longint p0, p1, p2, p3, input longint t,
                            output longint pt, output longint tan);
        longint e, f, g, h, i;
        e   = lerp_fx(p0, p1, t);
        f   = lerp_fx(p1, p2, t);
        g   = lerp_fx(p2, p3, t);
        h   = lerp_fx(e, f, t);
        i   = lerp_fx(f, g, t);
        pt  = lerp_fx(h, i, t);
        tan = 3 * (i - h);
    endtask

    function automatic longint unsigned mag(longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    // shift all three magnitudes by one count until each is below 2^30
    task automatic shrink3(ref longint w[3]);
        longint unsigned m;
        longint r;
        int s;
        m = 0;
        s = 0;
        for (int k = 0; k < 3; k++)
            if (mag(w[k]) > m) m = mag(w[k]);
        while ((m >> s) >= 64'h4000_0000) s++;
        for (int k = 0; k < 3; k++)
        begin
            r = longint'(mag(w[k]) >> s);
            w[k] = w[k] < 0 ? -r : r;
        end
    endtask

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(longint x);
        if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (x < -64'sh8000_0000) return 32'h8000_0000;
        return x[31:0];
    endfunction

    task automatic predict_patch_eval(input patch_cmd_t c, output surface_t r);
        longint tu[3], tv[3], pnt[3], cr[3], rc[4], cc[4];
        longint u, v, dummy;
        longint unsigned sum, len, n;
        logic [15:0] comp[3];
        u = c.pu > PARAM_ONE ? 65536 : longint'(c.pu);
        v = c.pv > PARAM_ONE ? 65536 : longint'(c.pv);
        for (int a = 0; a < 3; a++)
        begin
            for (int x = 0; x < 4; x++)
            begin
                cubic_at(ctrl_pts[(4*x)*3+a], ctrl_pts[(4*x+1)*3+a],
                         ctrl_pts[(4*x+2)*3+a], ctrl_pts[(4*x+3)*3+a], v, rc[x], dummy);
                cubic_at(ctrl_pts[x*3+a], ctrl_pts[(4+x)*3+a],
                         ctrl_pts[(8+x)*3+a], ctrl_pts[(12+x)*3+a], u, cc[x], dummy);
            end
            cubic_at(rc[0], rc[1], rc[2], rc[3], u, pnt[a], tu[a]);
            cubic_at(cc[0], cc[1], cc[2], cc[3], v, dummy, tv[a]);
        end
        shrink3(tu);
        shrink3(tv);
        cr[0] = tu[1] * tv[2] - tu[2] * tv[1];
        cr[1] = tu[2] * tv[0] - tu[0] * tv[2];
        cr[2] = tu[0] * tv[1] - tu[1] * tv[0];
        r.sx = sat32(pnt[0]);
        r.sy = sat32(pnt[1]);
        r.sz = sat32(pnt[2]);
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)
        begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
            return;
        end
        shrink3(cr);
        sum = 0;
        for (int a = 0; a < 3; a++) sum += mag(cr[a]) * mag(cr[a]);
        len = isqrt(sum);
        if (len == 0) len = 1;
        for (int a = 0; a < 3; a++)
        begin
            n = (mag(cr[a]) * 16384 + len / 2) / len;
            comp[a] = cr[a] < 0 ? 16'(-n) : 16'(n);
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2];
        r.degen = 1'b0;
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        surface_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (surface_expect_q.size() == 0)
                report_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
            else
            begin
                e = surface_expect_q.pop_front();
                if (m_tdata[31:0]    !== e.sx) report_mismatch("surf_x", m_tdata[31:0], e.sx);
                if (m_tdata[63:32]   !== e.sy) report_mismatch("surf_y", m_tdata[63:32], e.sy);
                if (m_tdata[95:64]   !== e.sz) report_mismatch("surf_z", m_tdata[95:64], e.sz);
                if (m_tdata[111:96]  !== e.nx)
                    report_mismatch("normal_x", 32'(m_tdata[111:96]), 32'(e.nx));
                if (m_tdata[127:112] !== e.ny)
                    report_mismatch("normal_y", 32'(m_tdata[127:112]), 32'(e.ny));
                if (m_tdata[143:128] !== e.nz)
                    report_mismatch("normal_z", 32'(m_tdata[143:128]), 32'(e.nz));
                if (m_tuser !== e.degen)
                    report_mismatch("normal_degenerate", 32'(m_tuser), 32'(e.degen));
            end
        end
    end

    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_bicubic_bezier_patch_eval: FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_beat(input patch_cmd_t c, input bit typed, input surface_t t);
        surface_t r;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = c.cmd;
        s_tdata  = {2'b00, c.pv, c.pu, c.cz, c.cy, c.cx, c.slot};
        do @(posedge clk); while (!s_tready);
        if (c.cmd == CMD_LOAD)
        begin
            ctrl_pts[c.slot*3]   = longint'(signed'(c.cx));
            ctrl_pts[c.slot*3+1] = longint'(signed'(c.cy));
            ctrl_pts[c.slot*3+2] = longint'(signed'(c.cz));
        end
        else
        begin
            predict_patch_eval(c, r);
            surface_expect_q = {surface_expect_q, typed ? t : r};
        end
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(4000)) - 2000);
            default: return 32'($signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] rand_param();
        case ($urandom_range(7))
            0: return 17'd0;
            1: return PARAM_ONE;
            2: return 17'($urandom_range(17'h1FFFF, 17'd65537));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic dir_row_t row(logic cmd, int s, logic [31:0] x, y, z,
                                     logic [16:0] u, v, bit typed, surface_t r);
        dir_row_t d;
        d.cmd.cmd = cmd; d.cmd.slot = s[3:0];
        d.cmd.cx = x; d.cmd.cy = y; d.cmd.cz = z;
        d.cmd.pu = u; d.cmd.pv = v;
        d.typed = typed; d.res = r;
        return d;
    endfunction

    initial
    begin
        dir_row_t   dir_rows[$];
        surface_t   flat, none;
        patch_cmd_t c;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_LOAD;
        m_tready   = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        send_idle  = 9;
        recv_idle  = 78;
        foreach (ctrl_pts[k]) ctrl_pts[k] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // flat patch at the coordinate extremes: point is the constant, no normal
        flat = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1};
        none = '{default: '0};
        for (int s = 0; s < NUM_SLOTS; s++)
            dir_rows = {dir_rows, row(CMD_LOAD, s, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                      17'd0, 17'd0, 1'b0, none)};
        dir_rows = {dir_rows, row(CMD_EVAL, 0, 0, 0, 0, 17'd0, 17'd0, 1'b1, flat)};
        dir_rows = {dir_rows, row(CMD_EVAL, 15, 32'hFFFF_FFFF, 0, 0,
                                  17'h1FFFF, 17'h1FFFF, 1'b1, flat)};
        dir_rows = {dir_rows, row(CMD_LOAD, 5, 32'h8000_0000, 32'h0, 32'h1,
                                  17'd0, 17'd0, 1'b0, none)};
        dir_rows = {dir_rows, row(CMD_LOAD, 10, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                  17'd0, 17'd0, 1'b0, none)};
        dir_rows = {dir_rows, row(CMD_LOAD, 15, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF,
                                  17'd0, 17'd0, 1'b0, none)};
        dir_rows = {dir_rows, row(CMD_LOAD, 0, 32'h0, 32'h0001_0000, 32'h0001_E240,
                                  17'd0, 17'd0, 1'b0, none)};
        dir_rows = {dir_rows, row(CMD_EVAL, 0, 0, 0, 0, PARAM_ONE, 17'd0, 1'b0, none)};
        dir_rows = {dir_rows, row(CMD_EVAL, 0, 0, 0, 0, 17'd0, PARAM_ONE, 1'b0, none)};
        dir_rows = {dir_rows, row(CMD_EVAL, 0, 0, 0, 0, 17'd32768, 17'd32768, 1'b0,
                                  none)};
        foreach (dir_rows[i])
            send_beat(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_idle = 78;
                recv_idle = 9;
                // hold off until every pending result is out
                while (surface_expect_q.size() != 0) @(posedge clk);
                @(negedge clk);
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            c.cmd  = ($urandom_range(99) < 40) ? CMD_EVAL : CMD_LOAD;
            c.slot = 4'($urandom_range(15));
            c.cx   = rand_coord();
            c.cy   = rand_coord();
            c.cz   = rand_coord();
            c.pu   = rand_param();
            c.pv   = rand_param();
            send_beat(c, 1'b0, none);
        end

        while (surface_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_bicubic_bezier_patch_eval: PASS");
        else
            $display("tb_bicubic_bezier_patch_eval: FAIL");
        $finish;
    end

endmodule

[bicubic_bezier_patch_eval.f]
design/bbp_pkg.sv
design/bbp_ram.sv
design/bicubic_bezier_patch_eval.sv
sim/tb_bicubic_bezier_patch_eval.sv
